// ===== rtl/sdp_pkg.sv =====
// Shared types and character constants for the strict decimal int32 parser.
package sdp_pkg;

	typedef enum logic [1:0] {
		PH_LEAD  = 2'd0,
		PH_SIGN  = 2'd1,
		PH_DIGIT = 2'd2,
		PH_ERR   = 2'd3
	} phase_t;

	localparam int unsigned ACC_W = 35;

	localparam logic [ACC_W-1:0] POS_LIMIT = 35'd2147483647;
	localparam logic [ACC_W-1:0] NEG_LIMIT = 35'd2147483648;

	localparam logic [7:0] CH_NUL   = 8'd0;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_PLUS  = 8'd43;
	localparam logic [7:0] CH_MINUS = 8'd45;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_NINE  = 8'd57;

	typedef struct packed {
		phase_t           phase;
		logic             negative;
		logic [ACC_W-1:0] acc;
	} parse_state_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] value;
		logic        error;
	} parse_result_t;

	localparam parse_state_t STATE_RESET = '{phase: PH_LEAD, negative: 1'b0, acc: '0};

endpackage

// ===== rtl/sdp_step.sv =====
// One-character parse step: next state and the result a NUL byte produces.
module sdp_step (
	input  sdp_pkg::parse_state_t  cur,
	input  logic [7:0]             char_byte,
	output sdp_pkg::parse_state_t  nxt,
	output sdp_pkg::parse_result_t res
);

	logic                      is_space;
	logic                      is_digit;
	logic [sdp_pkg::ACC_W-1:0] acc_new;
	logic [sdp_pkg::ACC_W-1:0] limit;
	logic [31:0]               mag;

	assign is_space = ((char_byte >= sdp_pkg::CH_TAB) && (char_byte <= sdp_pkg::CH_CR))
		|| (char_byte == sdp_pkg::CH_SPACE);
	assign is_digit = (char_byte >= sdp_pkg::CH_ZERO) && (char_byte <= sdp_pkg::CH_NINE);

	// acc*10 + digit as two shifts and adds, wrapped to the accumulator width
	assign acc_new = (cur.acc << 3) + (cur.acc << 1)
		+ sdp_pkg::ACC_W'(char_byte - sdp_pkg::CH_ZERO);
	assign limit   = cur.negative ? sdp_pkg::NEG_LIMIT : sdp_pkg::POS_LIMIT;
	assign mag     = cur.acc[31:0];

	always_comb begin
		nxt       = cur;
		res.valid = 1'b0;
		res.value = '0;
		res.error = 1'b0;
		if (char_byte == sdp_pkg::CH_NUL) begin
			res.valid = 1'b1;
			if (cur.phase == sdp_pkg::PH_DIGIT) begin
				res.value = cur.negative ? (32'd0 - mag) : mag;
			end else begin
				res.error = 1'b1;
			end
			nxt = sdp_pkg::STATE_RESET;
		end else begin
			case (cur.phase)
				sdp_pkg::PH_LEAD: begin
					if (is_space) begin
						nxt = cur;
					end else if ((char_byte == sdp_pkg::CH_MINUS)
							|| (char_byte == sdp_pkg::CH_PLUS)) begin
						nxt.negative = (char_byte == sdp_pkg::CH_MINUS);
						nxt.phase    = sdp_pkg::PH_SIGN;
					end else if (is_digit) begin
						nxt.acc   = acc_new;
						nxt.phase = (acc_new > limit) ? sdp_pkg::PH_ERR : sdp_pkg::PH_DIGIT;
					end else begin
						nxt.phase = sdp_pkg::PH_ERR;
					end
				end
				sdp_pkg::PH_SIGN, sdp_pkg::PH_DIGIT: begin
					if (is_digit) begin
						nxt.acc   = acc_new;
						nxt.phase = (acc_new > limit) ? sdp_pkg::PH_ERR : sdp_pkg::PH_DIGIT;
					end else begin
						nxt.phase = sdp_pkg::PH_ERR;
					end
				end
				default: begin
					nxt = cur;
				end
			endcase
		end
	end

endmodule

// ===== rtl/strict_decimal_int32_parser_top.sv =====
// Top level of the strict decimal int32 parser: input register, parse step, result register.
// A NUL byte's result is loaded into the result register when the byte leaves the input register.
// Throughput: 1 byte per cycle unless a NUL stalls; the only loop is the state update of the parse step
// (a multiply-by-ten add and a limit compare), closed through the state register.
// A byte stalls in the input register only while it is a NUL and the result register is full and not being drained.
// Reset (arst_n low, asynchronous): parse state returns to leading whitespace, all valids clear.
module strict_decimal_int32_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_byte
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] value
	output logic        m_tuser    // [0] error
);

	// input register stage
	logic       valid_s1;
	logic [7:0] byte_s1;

	// parse state and result register
	sdp_pkg::parse_state_t state_q;
	sdp_pkg::parse_state_t state_nxt;
	sdp_pkg::parse_result_t step_res;
	logic        out_valid_q;
	logic [31:0] value_q;
	logic        error_q;

	logic out_free;
	logic s1_advance;

	sdp_step u_step (
		.cur       (state_q),
		.char_byte (byte_s1),
		.nxt       (state_nxt),
		.res       (step_res)
	);

	// The result register can take a new result if empty or being drained this cycle.
	assign out_free = !out_valid_q || m_tready;
	// Non-NUL bytes never produce a result, so only a NUL waits on the output side.
	assign s1_advance = valid_s1 && (!step_res.valid || out_free);
	assign s_tready   = !valid_s1 || s1_advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sdp_pkg::STATE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_advance) begin
				state_q <= state_nxt;
			end
			if (s1_advance && step_res.valid) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload, loaded with the transfer that ends a string
	always_ff @(posedge clk) begin
		if (s1_advance && step_res.valid) begin
			value_q <= step_res.value;
			error_q <= step_res.error;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = value_q;
	assign m_tuser  = error_q;

endmodule

// ===== sim/strict_decimal_int32_parser_top_tb.sv =====
// Self-checking testbench for the strict decimal int32 parser: byte stream in, parsed values out.
`timescale 1ns / 1ps

module strict_decimal_int32_parser_top_tb;

	// Idle cycles with no transfer on either side before the run is abandoned.
	// Sender gaps and receiver stalls both come from idle_len().
	localparam int unsigned IDLE_LIMIT = 4000;
	// Extra cycles run after every expected result has come back.
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned RANDOM_CHARS = 450;

	typedef struct {
		logic [7:0]  ch;
		bit          hold;   // wait for all outstanding results before sending
		int unsigned gap;    // idle cycles after this transfer
	} char_item_t;

	typedef struct {
		logic [31:0] value;
		logic        error;
	} parsed_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = sdp_pkg::CH_NUL;     // [7:0] char_byte
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;              // [31:0] value
	logic        m_tuser;              // [0] error

	char_item_t  char_q[$];            // bytes still to be sent
	parsed_t     parsed_q[$];          // expected results, oldest first
	logic [7:0]  txt[$];               // scratch string under construction

	// Shadow of the parser state, advanced on every accepted byte
	sdp_pkg::phase_t           cur_phase = sdp_pkg::PH_LEAD;
	logic                      cur_neg = 1'b0;
	logic [sdp_pkg::ACC_W-1:0] cur_mag = '0;

	int unsigned gap_left = 0;
	int unsigned stall_left = 0;
	int unsigned calm_left = 0;
	int unsigned idle_cycles = 0;
	int unsigned strings_sent = 0;
	int unsigned results_taken = 0;
	int unsigned chars_sent = 0;
	int unsigned values_ok = 0;
	int unsigned values_rejected = 0;
	int unsigned fail_cnt = 0;
	parsed_t     got_exp;

	strict_decimal_int32_parser_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// One digit into the magnitude; range check depends on the sign seen
	function automatic void take_digit(input logic [7:0] c);
		logic [sdp_pkg::ACC_W-1:0] nxt;
		logic [sdp_pkg::ACC_W-1:0] lim;
		nxt = cur_mag * 35'd10 + sdp_pkg::ACC_W'(c - sdp_pkg::CH_ZERO);
		lim = cur_neg ? sdp_pkg::NEG_LIMIT : sdp_pkg::POS_LIMIT;
		cur_mag = nxt;
		cur_phase = (nxt > lim) ? sdp_pkg::PH_ERR : sdp_pkg::PH_DIGIT;
	endfunction

	// Advance the shadow state by one accepted byte; a NUL queues one result
	function automatic void advance_parse(input logic [7:0] c);
		parsed_t r;
		logic    wsp;
		logic    dig;
		wsp = (c >= sdp_pkg::CH_TAB && c <= sdp_pkg::CH_CR) || c == sdp_pkg::CH_SPACE;
		dig = c >= sdp_pkg::CH_ZERO && c <= sdp_pkg::CH_NINE;
		if (c == sdp_pkg::CH_NUL) begin
			if (cur_phase == sdp_pkg::PH_DIGIT) begin
				r.value = cur_neg ? -cur_mag[31:0] : cur_mag[31:0];
				r.error = 1'b0;
				values_ok++;
			end else begin
				r.value = '0;
				r.error = 1'b1;
				values_rejected++;
			end
			parsed_q.push_back(r);
			cur_phase = sdp_pkg::PH_LEAD;
			cur_neg = 1'b0;
			cur_mag = '0;
		end else begin
			case (cur_phase)
				sdp_pkg::PH_LEAD: begin
					if (wsp) begin
						// leading whitespace is skipped
					end else if (c == sdp_pkg::CH_PLUS || c == sdp_pkg::CH_MINUS) begin
						cur_neg = (c == sdp_pkg::CH_MINUS);
						cur_phase = sdp_pkg::PH_SIGN;
					end else if (dig) begin
						take_digit(c);
					end else begin
						cur_phase = sdp_pkg::PH_ERR;
					end
				end
				sdp_pkg::PH_SIGN, sdp_pkg::PH_DIGIT: begin
					if (dig)
						take_digit(c);
					else
						cur_phase = sdp_pkg::PH_ERR;
				end
				default: begin
					// error phase swallows everything up to NUL
				end
			endcase
		end
	endfunction

	function automatic void add_str(input string s);
		for (int i = 0; i < s.len(); i++)
			txt.push_back(s[i]);
	endfunction

	// Move the scratch string plus its NUL terminator into the send queue
	function automatic void queue_text(input bit hold, input bit calm);
		char_item_t it;
		txt.push_back(sdp_pkg::CH_NUL);
		foreach (txt[i]) begin
			it.ch = txt[i];
			it.hold = hold && i == 0;
			it.gap = calm ? 0 : idle_len();
			char_q.push_back(it);
		end
		txt.delete();
	endfunction

	function automatic logic [7:0] rand_space();
		int unsigned w;
		w = $urandom_range(8, 13);
		return (w == 8) ? sdp_pkg::CH_SPACE : 8'(w);
	endfunction

	// Well-formed number: optional blanks, optional sign, digits of chosen size
	function automatic void build_number();
		longint unsigned mag;
		int unsigned     s;
		repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 4) : 0)
			txt.push_back(rand_space());
		s = $urandom_range(0, 2);
		if (s == 1)
			txt.push_back(sdp_pkg::CH_PLUS);
		else if (s == 2)
			txt.push_back(sdp_pkg::CH_MINUS);
		case ($urandom_range(0, 5))
			0: mag = $urandom_range(0, 9);
			1: mag = $urandom_range(0, 99999);
			2: mag = $urandom;
			3: mag = 64'd2147483646 + $urandom_range(0, 3);  // straddles both limits
			4: mag = {$urandom, $urandom} % 64'd1000000000000;
			default: mag = 64'd21474836480 + $urandom_range(0, 9);
		endcase
		if ($urandom_range(0, 7) == 0)
			repeat ($urandom_range(1, 3))
				txt.push_back(sdp_pkg::CH_ZERO);
		add_str($sformatf("%0d", mag));
	endfunction

	initial begin
		int unsigned made;
		int unsigned kind;
		int unsigned pos;
		int unsigned nstr;

		// Directed: empty string
		queue_text(1'b0, 1'b0);
		// Blanks of both kinds and a sign with no digit after it
		txt = '{sdp_pkg::CH_SPACE, sdp_pkg::CH_TAB, sdp_pkg::CH_CR, sdp_pkg::CH_PLUS};
		queue_text(1'b0, 1'b0);
		// Most negative value, sent only after everything before has come back
		add_str("-2147483648");
		queue_text(1'b1, 1'b1);
		// Trailing character after digits
		add_str("9a");
		queue_text(1'b0, 1'b0);
		// Top-bit byte ahead of a digit is a non-digit
		txt = '{8'hFF, 8'h35};
		queue_text(1'b0, 1'b0);
		// Second sign after the first
		add_str("+-1");
		queue_text(1'b0, 1'b0);

		made = 0;
		nstr = 0;
		while (made < RANDOM_CHARS) begin
			kind = $urandom_range(0, 99);
			if (kind < 60) begin
				build_number();
			end else if (kind < 80) begin
				// well-formed number, then broken
				build_number();
				pos = $urandom_range(0, txt.size() - 1);
				case ($urandom_range(0, 2))
					0: txt.push_back(8'($urandom_range(1, 255)));
					1: txt[pos] = 8'($urandom_range(1, 255));
					default: txt.insert(pos, 8'($urandom_range(1, 255)));
				endcase
			end else begin
				repeat ($urandom_range(0, 6))
					txt.push_back(8'($urandom_range(1, 255)));
			end
			made += txt.size() + 1;
			queue_text(nstr == 30, $urandom_range(0, 4) == 0);
			nstr++;
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(posedge clk);
		while (char_q.size() != 0 || s_tvalid || parsed_q.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d strings in %0d byte transfers; %0d parsed to values, %0d rejected.",
			strings_sent, chars_sent, values_ok, values_rejected);
		$display("Covered blanks, signs, 32-bit limits, overflow, junk and high bytes.");
		if (fail_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Byte sender: advances when the current transfer completes or none is held
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= sdp_pkg::CH_NUL;
			gap_left <= 0;
		end else if (!s_tvalid || s_tready) begin
			if (gap_left != 0) begin
				s_tvalid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (char_q.size() == 0) begin
				s_tvalid <= 1'b0;
			end else if (char_q[0].hold && (s_tvalid || strings_sent != results_taken)) begin
				// hold off until the pipeline has handed back every result
				s_tvalid <= 1'b0;
			end else begin
				s_tvalid <= 1'b1;
				s_tdata <= char_q[0].ch;
				gap_left <= char_q[0].gap;
				void'(char_q.pop_front());
			end
		end
	end

	// Result receiver backpressure, with calm windows of no stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left <= 0;
			calm_left <= 0;
		end else if (stall_left != 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			m_tready <= 1'b1;
			if (calm_left != 0)
				calm_left <= calm_left - 1;
			else if ($urandom_range(0, 63) == 0)
				calm_left <= 100;
			else if ($urandom_range(0, 2) == 0)
				stall_left <= idle_len();
		end
	end

	// Monitor: predict on input transfers, check on result transfers
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				advance_parse(s_tdata);
				chars_sent <= chars_sent + 1;
				if (s_tdata == sdp_pkg::CH_NUL)
					strings_sent <= strings_sent + 1;
			end
			if (m_tvalid && m_tready) begin
				results_taken <= results_taken + 1;
				if (parsed_q.size() == 0) begin
					$error("unexpected result: value %0d error %0b", $signed(m_tdata), m_tuser);
					fail_cnt++;
				end else begin
					got_exp = parsed_q.pop_front();
					if (m_tdata !== got_exp.value) begin
						$error("value mismatch: expected %0d, got %0d",
							$signed(got_exp.value), $signed(m_tdata));
						fail_cnt++;
					end
					if (m_tuser !== got_exp.error) begin
						$error("error mismatch: expected %0b, got %0b", got_exp.error, m_tuser);
						fail_cnt++;
					end
				end
			end
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

endmodule
